@@ rtl/rcct_pkg.sv @@
package rcct_pkg;

	localparam int EDGE_COUNT_DEF = 6;
	localparam int EDGE_MAX = 6;
	localparam int EDGE_IDX_W = 3;

	localparam logic [7:0] DUTY_OFF = 8'hFF;
	localparam logic [7:0] DUTY_ON = 8'h00;
	localparam logic [7:0] STEP_LAST = 8'hFF;
	localparam logic [15:0] PERIOD_STEP = 16'd200;
	localparam logic [15:0] PERIOD_RESET = 16'd1000;

	localparam logic [7:0] DIR_ZERO = 8'h00;
	localparam logic [7:0] DIR_UP = 8'h01;
	localparam logic [7:0] DIR_DOWN = 8'hFF;

	// command characters
	localparam logic [7:0] CMD_RED_BRIGHT = 8'h52;   // R
	localparam logic [7:0] CMD_GREEN_BRIGHT = 8'h47; // G
	localparam logic [7:0] CMD_BLUE_BRIGHT = 8'h42;  // B
	localparam logic [7:0] CMD_RED_DIM = 8'h72;      // r
	localparam logic [7:0] CMD_GREEN_DIM = 8'h67;    // g
	localparam logic [7:0] CMD_BLUE_DIM = 8'h62;     // b
	localparam logic [7:0] CMD_TOUR_START = 8'h43;   // C
	localparam logic [7:0] CMD_TOUR_STOP = 8'h63;    // c
	localparam logic [7:0] CMD_ALL_OFF = 8'h61;      // a
	localparam logic [7:0] CMD_PERIOD_UP = 8'h2B;    // +
	localparam logic [7:0] CMD_PERIOD_DOWN = 8'h2D;  // -
	localparam logic [7:0] CMD_RESET = 8'h5A;        // Z

	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0] red_duty;
		logic [7:0] green_duty;
		logic [7:0] blue_duty;
		logic tour_on;
		logic [15:0] reload_value;
		logic reset_request;
		logic unknown_command;
	} result_t;

	function automatic rgb_t edge_dir(input logic [EDGE_IDX_W-1:0] idx);
		rgb_t d;
		d = '{red: DIR_ZERO, green: DIR_ZERO, blue: DIR_ZERO};
		case (idx)
			3'd0: d.green = DIR_DOWN;
			3'd1: d.blue = DIR_UP;
			3'd2: d.red = DIR_DOWN;
			3'd3: d.green = DIR_UP;
			3'd4: d.blue = DIR_DOWN;
			3'd5: d.red = DIR_UP;
			default: d = '{red: DIR_ZERO, green: DIR_ZERO, blue: DIR_ZERO};
		endcase
		return d;
	endfunction

endpackage

@@ rtl/rcct_core.sv @@
module rcct_core #(
	parameter int EDGE_COUNT = rcct_pkg::EDGE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic op,
	input logic [7:0] cmd,
	output rcct_pkg::result_t result
);

	localparam int IdxW = $clog2(EDGE_COUNT);
	localparam logic [IdxW-1:0] IdxLast = IdxW'(EDGE_COUNT - 1);

	logic [7:0] red_q, green_q, blue_q;
	logic tour_q;
	logic [IdxW-1:0] edge_q;
	logic [7:0] step_q;
	logic [15:0] period_q;

	logic [7:0] red_d, green_d, blue_d;
	logic tour_d;
	logic [IdxW-1:0] edge_d;
	logic [7:0] step_d;
	logic [15:0] period_d;
	logic reset_req;
	logic unknown;
	rcct_pkg::rgb_t dir;

	assign dir = rcct_pkg::edge_dir(rcct_pkg::EDGE_IDX_W'(edge_q));

	always_comb begin
		red_d = red_q;
		green_d = green_q;
		blue_d = blue_q;
		tour_d = tour_q;
		edge_d = edge_q;
		step_d = step_q;
		period_d = period_q;
		reset_req = 1'b0;
		unknown = 1'b0;
		if (op) begin
			if (tour_q) begin
				if (step_q != rcct_pkg::STEP_LAST) begin
					red_d = red_q + dir.red;
					green_d = green_q + dir.green;
					blue_d = blue_q + dir.blue;
					step_d = step_q + 8'd1;
				end else begin
					step_d = 8'd0;
					edge_d = (edge_q == IdxLast) ? '0 : edge_q + IdxW'(1);
				end
			end
		end else begin
			unique case (cmd)
				rcct_pkg::CMD_RED_BRIGHT: begin
					if (red_q != rcct_pkg::DUTY_ON) red_d = red_q - 8'd1;
				end
				rcct_pkg::CMD_GREEN_BRIGHT: begin
					if (green_q != rcct_pkg::DUTY_ON) green_d = green_q - 8'd1;
				end
				rcct_pkg::CMD_BLUE_BRIGHT: begin
					if (blue_q != rcct_pkg::DUTY_ON) blue_d = blue_q - 8'd1;
				end
				rcct_pkg::CMD_RED_DIM: begin
					if (red_q != rcct_pkg::DUTY_OFF) red_d = red_q + 8'd1;
				end
				rcct_pkg::CMD_GREEN_DIM: begin
					if (green_q != rcct_pkg::DUTY_OFF) green_d = green_q + 8'd1;
				end
				rcct_pkg::CMD_BLUE_DIM: begin
					if (blue_q != rcct_pkg::DUTY_OFF) blue_d = blue_q + 8'd1;
				end
				rcct_pkg::CMD_TOUR_START: begin
					red_d = rcct_pkg::DUTY_OFF;
					green_d = rcct_pkg::DUTY_OFF;
					blue_d = rcct_pkg::DUTY_ON;
					edge_d = '0;
					step_d = 8'd0;
					tour_d = 1'b1;
				end
				rcct_pkg::CMD_TOUR_STOP: begin
					tour_d = 1'b0;
				end
				rcct_pkg::CMD_ALL_OFF: begin
					red_d = rcct_pkg::DUTY_OFF;
					green_d = rcct_pkg::DUTY_OFF;
					blue_d = rcct_pkg::DUTY_OFF;
					tour_d = 1'b0;
				end
				rcct_pkg::CMD_PERIOD_UP: begin
					period_d = period_q + rcct_pkg::PERIOD_STEP;
				end
				rcct_pkg::CMD_PERIOD_DOWN: begin
					period_d = period_q - rcct_pkg::PERIOD_STEP;
				end
				rcct_pkg::CMD_RESET: begin
					reset_req = 1'b1;
				end
				default: begin
					unknown = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= rcct_pkg::DUTY_OFF;
			green_q <= rcct_pkg::DUTY_OFF;
			blue_q <= rcct_pkg::DUTY_OFF;
			tour_q <= 1'b0;
			edge_q <= '0;
			step_q <= 8'd0;
			period_q <= rcct_pkg::PERIOD_RESET;
		end else if (advance) begin
			red_q <= red_d;
			green_q <= green_d;
			blue_q <= blue_d;
			tour_q <= tour_d;
			edge_q <= edge_d;
			step_q <= step_d;
			period_q <= period_d;
		end
	end

	assign result.red_duty = red_d;
	assign result.green_duty = green_d;
	assign result.blue_duty = blue_d;
	assign result.tour_on = tour_d;
	assign result.reload_value = 16'd0 - period_d;
	assign result.reset_request = reset_req;
	assign result.unknown_command = unknown;

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		edge_q <= IdxLast)
		else $error("edge index beyond last edge");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op && !tour_q |=> $stable(red_q) && $stable(green_q) && $stable(blue_q)
			&& $stable(edge_q) && $stable(step_q))
		else $error("tick changed state while tour stopped");

	a_tour_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !op && cmd == rcct_pkg::CMD_TOUR_START |=>
			tour_q && blue_q == rcct_pkg::DUTY_ON && edge_q == '0 && step_q == 8'd0)
		else $error("tour start did not load blue corner");

	a_edge_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op && tour_q && step_q == rcct_pkg::STEP_LAST |=>
			step_q == 8'd0 && $stable(red_q) && $stable(green_q) && $stable(blue_q))
		else $error("edge change step altered duties");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !(result.reset_request && result.unknown_command)
			&& !(op && (result.reset_request || result.unknown_command)))
		else $error("flags raised together or on a tick");

endmodule

@@ rtl/rgb_color_cube_tour_controller.sv @@
// RGB LED controller with active-low 8-bit duties (0 fully on, 255 off). Each request on
// the input stream is a command byte (tuser 0) or a timer tick (tuser 1) and yields exactly
// one result carrying the duties, tour state, timer reload and the reset and unknown-command
// flags after that request. One request is taken every clock cycle while the output stream
// does not stall it; a result passes through one input register and one result register.
// Backpressure on the output stream reaches the input ready within the same cycle.
module rgb_color_cube_tour_controller #(
	parameter int EDGE_COUNT = rcct_pkg::EDGE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata,                         // cmd_byte
	input logic s_axis_tuser,                               // op
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [rcct_pkg::OUT_DATA_W-1:0] m_axis_tdata    // red_duty, green_duty, blue_duty,
	                                                        // tour_on, reload_value,
	                                                        // reset_request, unknown_command
);

	logic valid_s1;
	logic op_s1;
	logic [7:0] cmd_s1;
	logic advance;
	logic out_valid_q;
	rcct_pkg::result_t result;
	rcct_pkg::result_t out_q;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1 <= s_axis_tuser;
			cmd_s1 <= s_axis_tdata;
		end
	end

	rcct_core #(
		.EDGE_COUNT(EDGE_COUNT)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.op(op_s1),
		.cmd(cmd_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'd0, out_q.unknown_command, out_q.reset_request, out_q.reload_value,
		out_q.tour_on, out_q.blue_duty, out_q.green_duty, out_q.red_duty};

endmodule

@@ tb/rgb_color_cube_tour_controller_tb.sv @@
`timescale 1ns / 1ps

module rgb_color_cube_tour_controller_tb;

	localparam int EDGES = rcct_pkg::EDGE_COUNT_DEF;
	localparam bit OP_CMD = 1'b0;
	localparam bit OP_TICK = 1'b1;
	localparam int DIR_N = 25;
	localparam int RAND_N = 850;
	localparam int PAUSE_AT = 420;
	localparam int RX_HOLD_AT = DIR_N + 150;
	localparam int RX_HOLD = 300;
	localparam int DRAIN = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [15:0] RELOAD_RST = 16'd64536;

	// result fields from the highest bit down, same layout as m_axis_tdata
	typedef struct packed {
		logic unk;
		logic rst;
		logic [15:0] reload;
		logic tour;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} lamp_t;

	typedef struct packed {
		bit op;
		logic [7:0] cmd;
		bit typed;
		lamp_t want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;                   // cmd_byte
	logic s_axis_tuser;                         // op
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [rcct_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // red_duty, green_duty, blue_duty, tour_on,
	                                                // reload_value, reset_request,
	                                                // unknown_command

	// predictor state
	logic [7:0] duty_r = rcct_pkg::DUTY_OFF;
	logic [7:0] duty_g = rcct_pkg::DUTY_OFF;
	logic [7:0] duty_b = rcct_pkg::DUTY_OFF;
	bit touring = 1'b0;
	int unsigned leg = 0;
	logic [7:0] leg_step = 8'h00;
	logic [15:0] period = rcct_pkg::PERIOD_RESET;

	lamp_t lamp_q[$];
	step_row_t dir_rows [DIR_N];
	int sent_cnt = 0;
	int got_cnt = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit rx_held = 1'b0;
	lamp_t got_res;
	lamp_t want_res;

	rgb_color_cube_tour_controller #(
		.EDGE_COUNT(EDGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic lamp_t lamp_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic t, input logic [15:0] rl, input logic z,
			input logic u);
		lamp_t res;
		res.red = r;
		res.green = g;
		res.blue = b;
		res.tour = t;
		res.reload = rl;
		res.rst = z;
		res.unk = u;
		return res;
	endfunction

	// per-leg step as {blue, green, red}, two's complement
	function automatic logic [23:0] leg_delta(input int unsigned idx);
		case (idx % EDGES)
			0: return {8'h00, 8'hFF, 8'h00};
			1: return {8'h01, 8'h00, 8'h00};
			2: return {8'h00, 8'h00, 8'hFF};
			3: return {8'h00, 8'h01, 8'h00};
			4: return {8'hFF, 8'h00, 8'h00};
			default: return {8'h00, 8'h00, 8'h01};
		endcase
	endfunction

	function automatic lamp_t lamp_next(input bit op, input logic [7:0] cmd);
		lamp_t res;
		logic [23:0] d;
		res = '0;
		if (op == OP_TICK) begin
			if (touring) begin
				if (leg_step != rcct_pkg::STEP_LAST) begin
					d = leg_delta(leg);
					duty_r = duty_r + d[7:0];
					duty_g = duty_g + d[15:8];
					duty_b = duty_b + d[23:16];
					leg_step = leg_step + 8'd1;
				end else begin
					leg_step = 8'h00;
					leg = (leg % EDGES + 1) % EDGES;
				end
			end
		end else begin
			case (cmd)
				rcct_pkg::CMD_RED_BRIGHT: begin
					if (duty_r != rcct_pkg::DUTY_ON) duty_r = duty_r - 8'd1;
				end
				rcct_pkg::CMD_GREEN_BRIGHT: begin
					if (duty_g != rcct_pkg::DUTY_ON) duty_g = duty_g - 8'd1;
				end
				rcct_pkg::CMD_BLUE_BRIGHT: begin
					if (duty_b != rcct_pkg::DUTY_ON) duty_b = duty_b - 8'd1;
				end
				rcct_pkg::CMD_RED_DIM: begin
					if (duty_r != rcct_pkg::DUTY_OFF) duty_r = duty_r + 8'd1;
				end
				rcct_pkg::CMD_GREEN_DIM: begin
					if (duty_g != rcct_pkg::DUTY_OFF) duty_g = duty_g + 8'd1;
				end
				rcct_pkg::CMD_BLUE_DIM: begin
					if (duty_b != rcct_pkg::DUTY_OFF) duty_b = duty_b + 8'd1;
				end
				rcct_pkg::CMD_TOUR_START: begin
					duty_r = rcct_pkg::DUTY_OFF;
					duty_g = rcct_pkg::DUTY_OFF;
					duty_b = rcct_pkg::DUTY_ON;
					leg = 0;
					leg_step = 8'h00;
					touring = 1'b1;
				end
				rcct_pkg::CMD_TOUR_STOP: touring = 1'b0;
				rcct_pkg::CMD_ALL_OFF: begin
					duty_r = rcct_pkg::DUTY_OFF;
					duty_g = rcct_pkg::DUTY_OFF;
					duty_b = rcct_pkg::DUTY_OFF;
					touring = 1'b0;
				end
				rcct_pkg::CMD_PERIOD_UP: period = period + rcct_pkg::PERIOD_STEP;
				rcct_pkg::CMD_PERIOD_DOWN: period = period - rcct_pkg::PERIOD_STEP;
				rcct_pkg::CMD_RESET: res.rst = 1'b1;
				default: res.unk = 1'b1;
			endcase
		end
		res.red = duty_r;
		res.green = duty_g;
		res.blue = duty_b;
		res.tour = touring;
		res.reload = 16'h0000 - period;
		return res;
	endfunction

	task automatic offer(input bit op, input logic [7:0] cmd, input bit typed,
			input lamp_t typed_res);
		lamp_t res;
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		res = lamp_next(op, cmd);
		lamp_q.push_back(typed ? typed_res : res);
		sent_cnt++;
	endtask

	task automatic note_mismatch(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%0t result %0d %s: exp r=%02h g=%02h b=%02h tour=%0b rl=%04h z=%0b u=%0b",
				$realtime, got_cnt, what, want_res.red, want_res.green, want_res.blue,
				want_res.tour, want_res.reload, want_res.rst, want_res.unk);
			$display("%0t result %0d %s: got r=%02h g=%02h b=%02h tour=%0b rl=%04h z=%0b u=%0b",
				$realtime, got_cnt, what, got_res.red, got_res.green, got_res.blue,
				got_res.tour, got_res.reload, got_res.rst, got_res.unk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = lamp_t'(m_axis_tdata[$bits(lamp_t)-1:0]);
			if (lamp_q.size() == 0) begin
				want_res = 'x;
				note_mismatch("unexpected");
			end else begin
				want_res = lamp_q.pop_front();
				if (got_res.red !== want_res.red || got_res.green !== want_res.green ||
						got_res.blue !== want_res.blue || got_res.tour !== want_res.tour ||
						got_res.reload !== want_res.reload || got_res.rst !== want_res.rst ||
						got_res.unk !== want_res.unk)
					note_mismatch("mismatch");
			end
			got_cnt++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off to back up the block
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!rx_held && sent_cnt >= RX_HOLD_AT) begin
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				rx_held = 1'b1;
			end else begin
				stall = rx_calm ? 0 : $urandom_range(0, 16);
				if (stall != 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
		end
	end

	initial begin
		int pick;
		bit op;
		logic [7:0] cmd;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tuser <= OP_CMD;

		dir_rows[0] = '{OP_TICK, 8'h00, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b0)};
		dir_rows[1] = '{OP_CMD, rcct_pkg::CMD_RED_DIM, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b0)};
		dir_rows[2] = '{OP_CMD, rcct_pkg::CMD_RED_BRIGHT, 1'b1,
			lamp_of(8'hFE, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b0)};
		dir_rows[3] = '{OP_CMD, rcct_pkg::CMD_RESET, 1'b1,
			lamp_of(8'hFE, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b1, 1'b0)};
		dir_rows[4] = '{OP_CMD, 8'h3F, 1'b1,
			lamp_of(8'hFE, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b1)};
		dir_rows[5] = '{OP_CMD, 8'h7A, 1'b1,
			lamp_of(8'hFE, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b1)};
		dir_rows[6] = '{OP_CMD, 8'h00, 1'b1,
			lamp_of(8'hFE, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b1)};
		dir_rows[7] = '{OP_CMD, 8'hFF, 1'b1,
			lamp_of(8'hFE, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b1)};
		dir_rows[8] = '{OP_CMD, rcct_pkg::CMD_ALL_OFF, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'hFF, 1'b0, RELOAD_RST, 1'b0, 1'b0)};
		dir_rows[9] = '{OP_CMD, rcct_pkg::CMD_TOUR_START, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, RELOAD_RST, 1'b0, 1'b0)};
		dir_rows[10] = '{OP_CMD, rcct_pkg::CMD_BLUE_BRIGHT, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, RELOAD_RST, 1'b0, 1'b0)};
		dir_rows[11] = '{OP_TICK, 8'hA5, 1'b0, '0};
		dir_rows[12] = '{OP_CMD, rcct_pkg::CMD_GREEN_BRIGHT, 1'b0, '0};
		dir_rows[13] = '{OP_CMD, rcct_pkg::CMD_GREEN_DIM, 1'b0, '0};
		dir_rows[14] = '{OP_CMD, rcct_pkg::CMD_BLUE_DIM, 1'b0, '0};
		dir_rows[15] = '{OP_CMD, rcct_pkg::CMD_TOUR_STOP, 1'b0, '0};
		dir_rows[16] = '{OP_TICK, 8'h5A, 1'b0, '0};
		dir_rows[17] = '{OP_CMD, rcct_pkg::CMD_TOUR_START, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, RELOAD_RST, 1'b0, 1'b0)};
		dir_rows[18] = '{OP_CMD, rcct_pkg::CMD_PERIOD_DOWN, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, 16'd64736, 1'b0, 1'b0)};
		dir_rows[19] = '{OP_CMD, rcct_pkg::CMD_PERIOD_DOWN, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, 16'd64936, 1'b0, 1'b0)};
		dir_rows[20] = '{OP_CMD, rcct_pkg::CMD_PERIOD_DOWN, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, 16'd65136, 1'b0, 1'b0)};
		dir_rows[21] = '{OP_CMD, rcct_pkg::CMD_PERIOD_DOWN, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, 16'd65336, 1'b0, 1'b0)};
		dir_rows[22] = '{OP_CMD, rcct_pkg::CMD_PERIOD_DOWN, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, 16'd0, 1'b0, 1'b0)};
		dir_rows[23] = '{OP_CMD, rcct_pkg::CMD_PERIOD_DOWN, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, 16'd200, 1'b0, 1'b0)};
		dir_rows[24] = '{OP_CMD, rcct_pkg::CMD_PERIOD_UP, 1'b1,
			lamp_of(8'hFF, 8'hFF, 8'h00, 1'b1, 16'd0, 1'b0, 1'b0)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			offer(dir_rows[i].op, dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

		// mostly ticks on a running tour so the legs get walked
		offer(OP_CMD, rcct_pkg::CMD_TOUR_START, 1'b0, '0);
		for (int i = 0; i < RAND_N; i++) begin
			if (i == PAUSE_AT) begin
				s_axis_tvalid <= 1'b0;
				while (lamp_q.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 999);
			op = OP_CMD;
			cmd = 8'($urandom_range(0, 255));
			if (!touring && $urandom_range(0, 7) == 0)
				cmd = rcct_pkg::CMD_TOUR_START;
			else if (pick < 860)
				op = OP_TICK;
			else if (pick < 950) begin
				case ($urandom_range(0, 8))
					0: cmd = rcct_pkg::CMD_RED_BRIGHT;
					1: cmd = rcct_pkg::CMD_GREEN_BRIGHT;
					2: cmd = rcct_pkg::CMD_BLUE_BRIGHT;
					3: cmd = rcct_pkg::CMD_RED_DIM;
					4: cmd = rcct_pkg::CMD_GREEN_DIM;
					5: cmd = rcct_pkg::CMD_BLUE_DIM;
					6: cmd = rcct_pkg::CMD_PERIOD_UP;
					7: cmd = rcct_pkg::CMD_PERIOD_DOWN;
					default: cmd = rcct_pkg::CMD_RESET;
				endcase
			end else if (pick == 998)
				cmd = rcct_pkg::CMD_TOUR_START;
			else if (pick == 999)
				cmd = $urandom_range(0, 1) ? rcct_pkg::CMD_TOUR_STOP : rcct_pkg::CMD_ALL_OFF;
			offer(op, cmd, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (lamp_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rcct_pkg.sv
rtl/rcct_core.sv
rtl/rgb_color_cube_tour_controller.sv
tb/rgb_color_cube_tour_controller_tb.sv
